@@ design/filled_circle_span_generator_macros.svh @@
// Assertion macros used by the span queue of the filled-circle span generator.
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_MACROS_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define FCSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define FCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fcsg_pkg.sv @@
// Package with types, constants and the row-limit table of the span generator.
`default_nettype none
package fcsg_pkg;

  localparam int MaxRadiusDefault  = 24;
  localparam int QueueDepthDefault = 4;

  // One circle command beat.
  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [4:0]  radius;
    logic [15:0] fill_color;
  } cmd_t;

  // One span result beat.
  typedef struct packed {
    logic [15:0] span_x_start;
    logic [15:0] span_x_end;
    logic [15:0] span_row;
    logic [15:0] span_color;
    logic        last_span;
  } span_t;

  // Front sequencer states.
  typedef enum logic [2:0] {
    FsIdle,
    FsCenter,
    FsRow,
    FsOutMinus,
    FsInPlus,
    FsInMinus,
    FsFlush
  } front_state_e;

  // Push beat from the front into the span queue.
  typedef struct packed {
    logic  valid;
    span_t span;
  } push_t;

  // Span queue status seen by the front, the back and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Last row offset of the loop: radius * 0.707 rounded down, plus one.
  function automatic logic [4:0] row_limit(input logic [4:0] r);
    logic [4:0] lim;
    case (r)
      5'd1:    lim = 5'd1;
      5'd2:    lim = 5'd2;
      5'd3:    lim = 5'd3;
      5'd4:    lim = 5'd3;
      5'd5:    lim = 5'd4;
      5'd6:    lim = 5'd5;
      5'd7:    lim = 5'd5;
      5'd8:    lim = 5'd6;
      5'd9:    lim = 5'd7;
      5'd10:   lim = 5'd8;
      5'd11:   lim = 5'd8;
      5'd12:   lim = 5'd9;
      5'd13:   lim = 5'd10;
      5'd14:   lim = 5'd10;
      5'd15:   lim = 5'd11;
      5'd16:   lim = 5'd12;
      5'd17:   lim = 5'd13;
      5'd18:   lim = 5'd13;
      5'd19:   lim = 5'd14;
      5'd20:   lim = 5'd15;
      5'd21:   lim = 5'd15;
      5'd22:   lim = 5'd16;
      5'd23:   lim = 5'd17;
      5'd24:   lim = 5'd17;
      default: lim = 5'd17;
    endcase
    return lim;
  endfunction

endpackage
`default_nettype wire

@@ design/filled_circle_span_generator.sv @@
// Top level of the filled-circle span generator.
//
// A circle command beat (center, radius, color) is taken at a rising edge
// where start is high and busy is low. The block then returns the horizontal
// spans that fill the disc: the center row first, then for each row offset
// the optional outer pair and the inner pair, with last_span set on the
// final one. Each span appears on span_o for exactly one cycle, marked by
// span_strobe_o; the receiver cannot hold spans off.
// The front sequencer produces its spans in FsCenter, FsRow, FsOutMinus,
// FsInPlus and FsInMinus, passes a row offset whose spans are all empty in
// FsRow alone, closes in FsFlush, and stalls while the queue is full. Each
// span waits in a pending register, then passes through the queue and the
// output register. A circle of radius 24 gives 49 spans, and busy stays
// high until the queue has drained.
// Radius zero is treated as one and radii above MaxRadius as MaxRadius.
// Coordinates wrap at 16 bits. Reset returns the sequencer to idle and
// empties the queue; no clearing pass is needed.
`default_nettype none
module filled_circle_span_generator import fcsg_pkg::*; #(
  parameter int MaxRadius  = MaxRadiusDefault,
  parameter int QueueDepth = QueueDepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire cmd_t cmd_i,
  output logic      busy,
  output logic      span_strobe_o,
  output span_t     span_o
);

  logic      accept, front_idle, pop;
  push_t     push;
  q_status_t q_status;
  span_t     rd_span;

  // Command beat handshake.
  assign accept = start && !busy;
  assign busy   = !front_idle || !q_status.empty;

  fcsg_front #(
    .MaxRadius (MaxRadius)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .q_status_i (q_status),
    .push_o     (push),
    .idle_o     (front_idle)
  );

  fcsg_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop),
    .rd_span_o (rd_span),
    .status_o  (q_status)
  );

  fcsg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .rd_span_i     (rd_span),
    .pop_o         (pop),
    .span_strobe_o (span_strobe_o),
    .span_o        (span_o)
  );

endmodule
`default_nettype wire

@@ design/fcsg_front.sv @@
// Front sequencer: walks the rows of a circle command, stalling on a full queue.
`default_nettype none
module fcsg_front import fcsg_pkg::*; #(
  parameter int MaxRadius = MaxRadiusDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire cmd_t      cmd_i,
  input  wire q_status_t q_status_i,
  output push_t          push_o,
  output logic           idle_o
);

  front_state_e state_q, state_d;

  logic [15:0] cx_q, cy_q, color_q;
  logic [4:0]  r_q, i_q, x_q, ox_q, imax_q;
  logic [9:0]  sqmax_q;
  logic        pend_v_q;
  span_t       pend_q;

  // Radius saturated into the legal range.
  logic [4:0] r_sat;
  always_comb begin
    if (cmd_i.radius == 5'd0) begin
      r_sat = 5'd1;
    end else if (cmd_i.radius > 5'(MaxRadius)) begin
      r_sat = 5'(MaxRadius);
    end else begin
      r_sat = cmd_i.radius;
    end
  end

  // Edge test for the current row: i*i + x*x against r*r + r/2.
  logic [9:0]  ii, xx;
  logic [10:0] sum_sq;
  logic        step_x, outer, last_row;
  logic [4:0]  x_dec;
  assign ii       = 10'(i_q) * 10'(i_q);
  assign xx       = 10'(x_q) * 10'(x_q);
  assign sum_sq   = {1'b0, ii} + {1'b0, xx};
  assign step_x   = sum_sq > {1'b0, sqmax_q};
  assign x_dec    = (step_x && (x_q != 5'd0)) ? (x_q - 5'd1) : x_q;
  assign outer    = step_x && (x_q > imax_q) && (i_q != 5'd1);
  assign last_row = (i_q == imax_q);

  // Span candidate of this cycle.
  logic        emit;
  logic [15:0] c_start, c_row;
  logic [5:0]  c_len;
  logic        row_end;
  always_comb begin
    emit    = 1'b0;
    c_start = cx_q - 16'(x_q);
    c_row   = cy_q + 16'(i_q);
    c_len   = {x_q, 1'b0};
    row_end = 1'b0;
    unique case (state_q)
      FsCenter: begin
        emit    = 1'b1;
        c_start = cx_q - 16'(r_q);
        c_row   = cy_q;
        c_len   = {r_q, 1'b0};
      end
      FsRow: begin
        if (outer) begin
          emit    = 1'b1;
          c_start = cx_q - 16'(i_q) + 16'd1;
          c_row   = cy_q + 16'(x_q);
          c_len   = {i_q - 5'd1, 1'b0};
        end else begin
          emit    = (x_dec != 5'd0);
          c_start = cx_q - 16'(x_dec);
          c_row   = cy_q + 16'(i_q);
          c_len   = {x_dec, 1'b0};
          row_end = (x_dec == 5'd0);
        end
      end
      FsOutMinus: begin
        emit    = 1'b1;
        c_start = cx_q - 16'(i_q) + 16'd1;
        c_row   = cy_q - 16'(ox_q);
        c_len   = {i_q - 5'd1, 1'b0};
        row_end = (x_q == 5'd0);
      end
      FsInPlus: begin
        emit = 1'b1;
      end
      FsInMinus: begin
        emit    = 1'b1;
        c_row   = cy_q - 16'(i_q);
        row_end = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  span_t cand;
  always_comb begin
    cand.span_x_start = c_start;
    cand.span_x_end   = c_start + 16'(c_len) - 16'd1;
    cand.span_row     = c_row;
    cand.span_color   = color_q;
    cand.last_span    = 1'b0;
  end

  // The pending span goes to the queue once its successor, or the end, is known.
  logic flushing, hold, advance;
  assign flushing = (state_q == FsFlush);
  assign hold     = pend_v_q && q_status_i.full && (emit || flushing);
  assign advance  = !hold;

  always_comb begin
    push_o.valid          = pend_v_q && !q_status_i.full && (emit || flushing);
    push_o.span           = pend_q;
    push_o.span.last_span = flushing;
  end

  assign idle_o = (state_q == FsIdle);

  // Next state.
  always_comb begin
    state_d = state_q;
    if (advance) begin
      unique case (state_q)
        FsIdle:     if (accept_i) state_d = FsCenter;
        FsCenter:   state_d = FsRow;
        FsRow:      if (outer) state_d = FsOutMinus;
                    else if (x_dec != 5'd0) state_d = FsInMinus;
                    else state_d = last_row ? FsFlush : FsRow;
        FsOutMinus: if (x_q != 5'd0) state_d = FsInPlus;
                    else state_d = last_row ? FsFlush : FsRow;
        FsInPlus:   state_d = FsInMinus;
        FsInMinus:  state_d = last_row ? FsFlush : FsRow;
        FsFlush:    state_d = FsIdle;
        default:    state_d = FsIdle;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FsIdle;
      pend_v_q <= 1'b0;
      i_q      <= 5'd0;
      x_q      <= 5'd0;
      imax_q   <= 5'd0;
      sqmax_q  <= 10'd0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        if (emit) begin
          pend_v_q <= 1'b1;
        end else if (flushing) begin
          pend_v_q <= 1'b0;
        end
        if (state_q == FsIdle && accept_i) begin
          i_q     <= 5'd1;
          x_q     <= r_sat;
          imax_q  <= row_limit(r_sat);
          sqmax_q <= 10'(r_sat) * 10'(r_sat) + 10'(r_sat >> 1);
        end else begin
          if (state_q == FsRow) begin
            x_q <= x_dec;
          end
          if (row_end && !last_row) begin
            i_q <= i_q + 5'd1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (emit) begin
        pend_q <= cand;
      end
      if (state_q == FsIdle && accept_i) begin
        cx_q    <= cmd_i.center_x;
        cy_q    <= cmd_i.center_y;
        color_q <= cmd_i.fill_color;
        r_q     <= r_sat;
      end
      if (state_q == FsRow) begin
        ox_q <= x_q;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/fcsg_queue.sv @@
// Short span queue between the front sequencer and the output stage.
`default_nettype none
`include "filled_circle_span_generator_macros.svh"
module fcsg_queue import fcsg_pkg::*; #(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  input  wire logic  pop_i,
  output span_t      rd_span_o,
  output q_status_t  status_o
);

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);

  span_t         mem_q [QueueDepth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  // Pointer increment with wrap at the queue depth.
  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(QueueDepth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign status_o.full  = (count_q == CW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign rd_span_o      = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i.valid && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (!push_i.valid && pop_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.span;
    end
  end

  // A push without a pop must raise the fill count by one.
  logic          push_only;
  logic [CW-1:0] count_inc;
  assign push_only = push_i.valid && !pop_i;
  assign count_inc = count_q + CW'(1);

  `FCSG_ASSERT_IMP(a_no_overflow, push_i.valid, !status_o.full, "span queue overflow")
  `FCSG_ASSERT_IMP(a_no_underflow, pop_i, !status_o.empty, "span queue underflow")
  `FCSG_ASSERT_NEXT(a_count_up, push_only, count_q == $past(count_inc), "push did not raise count")

endmodule
`default_nettype wire

@@ design/fcsg_back.sv @@
// Output stage: drains the span queue into the registered result strobe.
`default_nettype none
module fcsg_back import fcsg_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire q_status_t q_status_i,
  input  wire span_t     rd_span_i,
  output logic           pop_o,
  output logic           span_strobe_o,
  output span_t          span_o
);

  logic  strobe_q;
  span_t span_q;

  // The receiver never stalls, so a waiting span is taken every cycle.
  assign pop_o = !q_status_i.empty;

  // Strobe register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= pop_o;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      span_q <= rd_span_i;
    end
  end

  assign span_strobe_o = strobe_q;
  assign span_o        = span_q;

endmodule
`default_nettype wire

@@ tb/filled_circle_span_generator_test.sv @@
// Self-checking testbench for the filled-circle span generator.
module filled_circle_span_generator_test;
  import fcsg_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SpanCap    = 64;
  localparam int DrainWait  = 20;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  cmd_t  circle_cmd;
  logic  busy;
  logic  span_strobe;
  span_t span;

  // Spans still owed by the block, oldest first.
  span_t expected_spans[$];
  int    circle_span_count;
  int    mismatch_count;
  int    stall_cycles;
  int    send_idle_pct;

  // Predictor copy of the block's loop state after the last circle.
  logic [4:0] pred_row_offset;
  logic [4:0] pred_edge_x;
  logic [4:0] pred_row_limit;
  logic [9:0] pred_square_limit;

  filled_circle_span_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .cmd_i         (circle_cmd),
    .busy          (busy),
    .span_strobe_o (span_strobe),
    .span_o        (span)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Queues one span, dropping empty ones and anything past the span cap.
  function automatic void push_span(input int unsigned col, input int unsigned row,
                                    input int unsigned len, input logic [15:0] color);
    span_t s;
    if (len == 0 || circle_span_count >= SpanCap) return;
    s.span_x_start = 16'(col);
    s.span_x_end   = 16'(col + len - 1);
    s.span_row     = 16'(row);
    s.span_color   = color;
    s.last_span    = 1'b0;
    expected_spans.push_back(s);
    circle_span_count++;
  endfunction

  // Works out every span of one circle command and appends them in order.
  function automatic void predict_circle(input cmd_t c);
    int unsigned r, imax, sqmax, x, i;
    r = c.radius;
    if (r < 1) r = 1;
    if (r > MaxRadiusDefault) r = MaxRadiusDefault;
    imax  = r * 707 / 1000 + 1;
    sqmax = r * r + r / 2;
    x     = r;
    circle_span_count = 0;
    // The center row comes first.
    push_span(c.center_x - r, c.center_y, 2 * r, c.fill_color);
    for (i = 1; i <= imax; i++) begin
      // Step the edge in; the outer pair goes out while the edge is still steep.
      if (i * i + x * x > sqmax) begin
        if (x > imax) begin
          push_span(c.center_x - i + 1, c.center_y + x, 2 * (i - 1), c.fill_color);
          push_span(c.center_x - i + 1, c.center_y - x, 2 * (i - 1), c.fill_color);
        end
        if (x > 0) x--;
      end
      push_span(c.center_x - x, c.center_y + i, 2 * x, c.fill_color);
      push_span(c.center_x - x, c.center_y - i, 2 * x, c.fill_color);
      pred_row_offset = 5'(i);
    end
    pred_edge_x       = 5'(x);
    pred_row_limit    = 5'(imax);
    pred_square_limit = 10'(sqmax);
    if (circle_span_count > 0)
      expected_spans[expected_spans.size() - 1].last_span = 1'b1;
  endfunction

  // Compares one field of a span beat.
  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Predicts on every accepted command, checks every span beat and runs the watchdog.
  always @(posedge clk_i) begin : span_monitor
    span_t want;
    if (rst_ni) begin
      stall_cycles++;
      if (start && !busy) begin
        predict_circle(circle_cmd);
        stall_cycles = 0;
      end
      if (span_strobe) begin
        stall_cycles = 0;
        if (expected_spans.size() == 0) begin
          report_mismatch("span beat with nothing expected");
        end else begin
          want = expected_spans.pop_front();
          check_field("span_x_start", span.span_x_start, want.span_x_start);
          check_field("span_x_end", span.span_x_end, want.span_x_end);
          check_field("span_row", span.span_row, want.span_row);
          check_field("span_color", span.span_color, want.span_color);
          check_field("last_span", 16'(span.last_span), 16'(want.last_span));
        end
      end
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles", StallLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Sends one command, idling start at random while waiting for the block.
  task automatic send_circle(input cmd_t c);
    bit taken;
    taken = 1'b0;
    @(negedge clk_i);
    circle_cmd <= c;
    while (!taken) begin
      start <= ($urandom_range(99) >= send_idle_pct);
      @(posedge clk_i);
      taken = start && !busy;
      if (!taken) @(negedge clk_i);
    end
  endtask

  // Drops start so that no stale command gets taken again.
  task automatic release_start();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Random circle: mostly legal radii, some near the coordinate wrap points.
  function automatic cmd_t random_circle();
    cmd_t c;
    if ($urandom_range(99) < 5) c.radius = ($urandom_range(1) == 0) ? 5'd0
                                           : 5'($urandom_range(25, 31));
    else c.radius = 5'($urandom_range(1, MaxRadiusDefault));
    c.center_x = 16'($urandom);
    c.center_y = 16'($urandom);
    if ($urandom_range(3) == 0) c.center_x = 16'($urandom_range(0, 30) - 15);
    if ($urandom_range(3) == 0) c.center_y = 16'($urandom_range(0, 30) - 15);
    c.fill_color = 16'($urandom);
    return c;
  endfunction

  // Every legal radius, with centers and colors at the extremes so spans wrap.
  task automatic test_radius_sweep();
    cmd_t c;
    for (int r = 1; r <= MaxRadiusDefault; r++) begin
      c.radius     = 5'(r);
      c.center_x   = r[0] ? 16'hFFFF : 16'h0000;
      c.center_y   = r[1] ? 16'h0000 : 16'hFFFF;
      c.fill_color = r[0] ? 16'hFFFF : 16'h0000;
      send_circle(c);
    end
  endtask

  // Radius zero and the largest field value are both clamped by the block.
  task automatic test_radius_clamp();
    cmd_t c;
    c.center_x   = 16'h8000;
    c.center_y   = 16'h7FFF;
    c.fill_color = 16'hA5A5;
    c.radius     = 5'd0;
    send_circle(c);
    c.radius     = 5'd31;
    c.fill_color = 16'h5A5A;
    send_circle(c);
  endtask

  // A run of random circles with the given sender idle rate.
  task automatic test_random_circles(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    repeat (count) send_circle(random_circle());
  endtask

  // Reset, directed tests, three random phases, then drain and verdict.
  initial begin
    rst_ni            = 1'b0;
    start             = 1'b0;
    circle_cmd        = '0;
    mismatch_count    = 0;
    stall_cycles      = 0;
    send_idle_pct     = 11;
    circle_span_count = 0;
    pred_row_offset   = '0;
    pred_edge_x       = '0;
    pred_row_limit    = '0;
    pred_square_limit = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_radius_sweep();
    test_radius_clamp();
    test_random_circles(115, 11);
    test_random_circles(115, 51);
    test_random_circles(115, 0);
    release_start();

    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (expected_spans.size() != 0)
      report_mismatch($sformatf("%0d spans never arrived", expected_spans.size()));
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
